// ===== rtl/bfe_pkg.sv =====
package bfe_pkg;

    localparam int CoordBits = 4;
    localparam int GridSize  = 1 << CoordBits;
    localparam int Cells     = GridSize * GridSize;
    localparam int IdxBits   = 2 * CoordBits;
    localparam int DepthBits = IdxBits + 1;
    localparam int PixelBits = 32;
    localparam int DimBits   = CoordBits + 1;
    localparam int CmdBits   = 2;
    localparam int UpcBits   = 4;

    localparam logic [CmdBits-1:0] CMD_WRITE = 2'd0;
    localparam logic [CmdBits-1:0] CMD_READ  = 2'd1;
    localparam logic [CmdBits-1:0] CMD_FILL  = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [3:0] t_act;
    localparam t_act A_NONE     = 4'd0;
    localparam t_act A_LATCH    = 4'd1;
    localparam t_act A_WRITE    = 4'd2;
    localparam t_act A_READ_POS = 4'd3;
    localparam t_act A_CAPTURE  = 4'd4;
    localparam t_act A_DONE     = 4'd5;
    localparam t_act A_SEED     = 4'd6;
    localparam t_act A_PROBE    = 4'd7;
    localparam t_act A_PAINT    = 4'd8;
    localparam t_act A_POP      = 4'd9;
    localparam t_act A_LOAD     = 4'd10;

    typedef logic [3:0] t_cond;
    localparam t_cond C_NEXT     = 4'd0;
    localparam t_cond C_ALWAYS   = 4'd1;
    localparam t_cond C_NO_START = 4'd2;
    localparam t_cond C_CMD_FILL = 4'd3;
    localparam t_cond C_CMD_READ = 4'd4;
    localparam t_cond C_SEED_BAD = 4'd5;
    localparam t_cond C_PIX_EQ   = 4'd6;
    localparam t_cond C_SKIP     = 4'd7;
    localparam t_cond C_DIR_DONE = 4'd8;
    localparam t_cond C_LAST     = 4'd9;

    typedef struct packed {
        t_act               act;
        t_cond              cond;
        logic [UpcBits-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic start;
        logic cmd_fill;
        logic cmd_read;
        logic seed_bad;
        logic pix_eq;
        logic skip;
        logic dir_done;
        logic last;
    } t_flags;

    typedef struct packed {
        logic [IdxBits-1:0] idx;
        logic [1:0]         dir;
    } t_frame;

    function automatic logic [DimBits-1:0] clamp_dim(input logic [DimBits-1:0] v);
        logic [DimBits-1:0] r;
        begin
            if (v == '0) begin
                r = DimBits'(1);
            end else if (v > DimBits'(GridSize)) begin
                r = DimBits'(GridSize);
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/bfe_bitmap.sv =====
module bfe_bitmap (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [bfe_pkg::IdxBits-1:0]       i_waddr,
    input  logic [bfe_pkg::PixelBits-1:0]     i_wdata,
    input  logic                              i_re,
    input  logic [bfe_pkg::IdxBits-1:0]       i_raddr,
    output logic [bfe_pkg::PixelBits-1:0]     o_rdata
);
    import bfe_pkg::*;

    logic [PixelBits-1:0] r_mem [Cells];
    logic [Cells-1:0]     r_vld;
    logic [PixelBits-1:0] r_q;
    logic                 r_qv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q  <= r_mem[i_raddr];
            r_qv <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_qv ? r_q : '0;

endmodule

// ===== rtl/bfe_stack.sv =====
module bfe_stack (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [bfe_pkg::IdxBits-1:0]   i_waddr,
    input  bfe_pkg::t_frame               i_wdata,
    input  logic                          i_re,
    input  logic [bfe_pkg::IdxBits-1:0]   i_raddr,
    output bfe_pkg::t_frame               o_rdata
);
    import bfe_pkg::*;

    t_frame r_mem [Cells];
    t_frame r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== rtl/bfe_useq.sv =====
module bfe_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfe_pkg::t_flags   i_flags,
    output bfe_pkg::t_ctrl    o_ctrl,
    output logic              o_busy
);
    import bfe_pkg::*;

    localparam logic [UpcBits-1:0] S_IDLE      = 4'd0;
    localparam logic [UpcBits-1:0] S_DISP      = 4'd1;
    localparam logic [UpcBits-1:0] S_DISP2     = 4'd2;
    localparam logic [UpcBits-1:0] S_WRITE     = 4'd3;
    localparam logic [UpcBits-1:0] S_READ      = 4'd4;
    localparam logic [UpcBits-1:0] S_CAPT      = 4'd5;
    localparam logic [UpcBits-1:0] S_DONE      = 4'd6;
    localparam logic [UpcBits-1:0] S_SEED_RD   = 4'd7;
    localparam logic [UpcBits-1:0] S_SEED_CHK  = 4'd8;
    localparam logic [UpcBits-1:0] S_SEED_PUSH = 4'd9;
    localparam logic [UpcBits-1:0] S_PROBE     = 4'd10;
    localparam logic [UpcBits-1:0] S_CHECK     = 4'd11;
    localparam logic [UpcBits-1:0] S_PAINT     = 4'd12;
    localparam logic [UpcBits-1:0] S_POP       = 4'd13;
    localparam logic [UpcBits-1:0] S_LOAD      = 4'd14;

    function automatic t_ctrl rom(input logic [UpcBits-1:0] a);
        t_ctrl c;
        begin
            case (a)
                S_IDLE:      c = '{A_LATCH,    C_NO_START, S_IDLE};
                S_DISP:      c = '{A_NONE,     C_CMD_FILL, S_SEED_RD};
                S_DISP2:     c = '{A_NONE,     C_CMD_READ, S_READ};
                S_WRITE:     c = '{A_WRITE,    C_ALWAYS,   S_DONE};
                S_READ:      c = '{A_READ_POS, C_NEXT,     S_IDLE};
                S_CAPT:      c = '{A_CAPTURE,  C_NEXT,     S_IDLE};
                S_DONE:      c = '{A_DONE,     C_ALWAYS,   S_IDLE};
                S_SEED_RD:   c = '{A_READ_POS, C_SEED_BAD, S_DONE};
                S_SEED_CHK:  c = '{A_NONE,     C_PIX_EQ,   S_DONE};
                S_SEED_PUSH: c = '{A_SEED,     C_NEXT,     S_IDLE};
                S_PROBE:     c = '{A_PROBE,    C_DIR_DONE, S_POP};
                S_CHECK:     c = '{A_NONE,     C_SKIP,     S_PROBE};
                S_PAINT:     c = '{A_PAINT,    C_ALWAYS,   S_PROBE};
                S_POP:       c = '{A_POP,      C_LAST,     S_DONE};
                S_LOAD:      c = '{A_LOAD,     C_ALWAYS,   S_PROBE};
                default:     c = '{A_NONE,     C_ALWAYS,   S_IDLE};
            endcase
            return c;
        end
    endfunction

    logic [UpcBits-1:0] r_upc;
    logic [UpcBits-1:0] n_upc;
    t_ctrl              ctrl;
    logic               take;

    assign ctrl = rom(r_upc);

    always_comb begin
        case (ctrl.cond)
            C_NEXT:     take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_START: take = !i_flags.start;
            C_CMD_FILL: take = i_flags.cmd_fill;
            C_CMD_READ: take = i_flags.cmd_read;
            C_SEED_BAD: take = i_flags.seed_bad;
            C_PIX_EQ:   take = i_flags.pix_eq;
            C_SKIP:     take = i_flags.skip;
            C_DIR_DONE: take = i_flags.dir_done;
            C_LAST:     take = i_flags.last;
            default:    take = 1'b1;
        endcase
        n_upc = take ? ctrl.target : r_upc + UpcBits'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl = ctrl;
    assign o_busy = (r_upc != S_IDLE);

endmodule

// ===== rtl/boundary_fill_engine.sv =====
// 16 x 16 bitmap of 32-bit RGBA pixels, zero after reset, with write, read and
// 4-connected boundary fill commands. Raise i_start with a command while o_busy is
// low; exactly one result follows on o_read_value / o_done_command, marked by
// o_result_strobe for a single cycle, and the receiver cannot stall it. A fill
// ends without painting when the seed lies outside the active area or already
// holds the fill color; otherwise each painted pixel costs four probes (a neighbour
// read and a check each), one paint, one exhausted-direction check, one pop and
// one reload of the frame below. The microcode sequencer runs one step per cycle
// and every probe waits on the single bitmap read port. A new command may be
// started in the cycle the strobe is high. Write the active width and height only
// while o_busy is low and no result is pending.
module boundary_fill_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [bfe_pkg::CmdBits-1:0]       i_command,
    input  logic [bfe_pkg::CoordBits-1:0]     i_pos_x,
    input  logic [bfe_pkg::CoordBits-1:0]     i_pos_y,
    input  logic [bfe_pkg::PixelBits-1:0]     i_pixel_value,
    output logic                              o_result_strobe,
    output logic [bfe_pkg::PixelBits-1:0]     o_read_value,
    output logic [bfe_pkg::CmdBits-1:0]       o_done_command,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [bfe_pkg::DimBits-1:0]       i_cfg_data
);
    import bfe_pkg::*;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    t_ctrl                 ctrl;
    t_flags                flags;

    logic [CmdBits-1:0]    r_cmd;
    logic [CoordBits-1:0]  r_x;
    logic [CoordBits-1:0]  r_y;
    logic [PixelBits-1:0]  r_color;
    logic [PixelBits-1:0]  r_rv;
    logic [DimBits-1:0]    r_w;
    logic [DimBits-1:0]    r_h;
    logic [IdxBits-1:0]    r_cur;
    logic [2:0]            r_dir;
    logic [1:0]            r_pd;
    logic [IdxBits-1:0]    r_nbr;
    logic                  r_ok;
    logic [DepthBits-1:0]  r_sp;
    logic                  r_strobe;

    logic [IdxBits-1:0]    pos_idx;
    logic [CoordBits-1:0]  cx;
    logic [CoordBits-1:0]  cy;
    logic                  probe_ok;
    logic [IdxBits-1:0]    probe_nbr;

    logic                  bm_we;
    logic [IdxBits-1:0]    bm_waddr;
    logic                  bm_re;
    logic [IdxBits-1:0]    bm_raddr;
    logic [PixelBits-1:0]  bm_rdata;

    logic                  st_we;
    logic [IdxBits-1:0]    st_waddr;
    t_frame                st_wdata;
    logic                  st_re;
    logic [IdxBits-1:0]    st_raddr;
    t_frame                st_rdata;
    logic [DepthBits-1:0]  sp_m1;
    logic [DepthBits-1:0]  sp_m2;

    assign pos_idx = {r_y, r_x};
    assign cx      = r_cur[CoordBits-1:0];
    assign cy      = r_cur[IdxBits-1:CoordBits];
    assign sp_m1   = r_sp - DepthBits'(1);
    assign sp_m2   = r_sp - DepthBits'(2);

    always_comb begin
        case (r_dir[1:0])
            DIR_LEFT: begin
                probe_ok  = (cx != '0);
                probe_nbr = r_cur - IdxBits'(1);
            end
            DIR_RIGHT: begin
                probe_ok  = (({1'b0, cx} + DimBits'(1)) < r_w);
                probe_nbr = r_cur + IdxBits'(1);
            end
            DIR_UP: begin
                probe_ok  = (cy != '0);
                probe_nbr = r_cur - IdxBits'(GridSize);
            end
            DIR_DOWN: begin
                probe_ok  = (({1'b0, cy} + DimBits'(1)) < r_h);
                probe_nbr = r_cur + IdxBits'(GridSize);
            end
            default: begin
                probe_ok  = 1'b0;
                probe_nbr = r_cur;
            end
        endcase
    end

    always_comb begin
        flags.start    = i_start;
        flags.cmd_fill = (r_cmd == CMD_FILL);
        flags.cmd_read = (r_cmd == CMD_READ);
        flags.seed_bad = ({1'b0, r_x} >= r_w) || ({1'b0, r_y} >= r_h);
        flags.pix_eq   = (bm_rdata == r_color);
        flags.skip     = !r_ok || (bm_rdata == r_color);
        flags.dir_done = r_dir[2];
        flags.last     = (r_sp == DepthBits'(1));
    end

    bfe_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl),
        .o_busy  (o_busy)
    );

    always_comb begin
        bm_we    = 1'b0;
        bm_waddr = pos_idx;
        bm_re    = 1'b0;
        bm_raddr = pos_idx;
        case (ctrl.act)
            A_WRITE: begin
                bm_we = (r_cmd == CMD_WRITE);
            end
            A_SEED: begin
                bm_we = 1'b1;
            end
            A_PAINT: begin
                bm_we    = 1'b1;
                bm_waddr = r_nbr;
            end
            A_READ_POS: begin
                bm_re = 1'b1;
            end
            A_PROBE: begin
                bm_re    = 1'b1;
                bm_raddr = probe_nbr;
            end
            default: begin
            end
        endcase
    end

    bfe_bitmap u_bitmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (r_color),
        .i_re    (bm_re),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    assign st_we        = (ctrl.act == A_PAINT);
    assign st_waddr     = sp_m1[IdxBits-1:0];
    assign st_wdata.idx = r_cur;
    assign st_wdata.dir = r_pd;
    assign st_re        = (ctrl.act == A_POP);
    assign st_raddr     = sp_m2[IdxBits-1:0];

    bfe_stack u_stack (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w      <= DimBits'(GridSize);
            r_h      <= DimBits'(GridSize);
            r_sp     <= '0;
            r_strobe <= 1'b0;
            r_cmd    <= CMD_WRITE;
            r_rv     <= '0;
        end else begin
            r_strobe <= (ctrl.act == A_DONE);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_WIDTH:  r_w <= clamp_dim(i_cfg_data);
                    REG_HEIGHT: r_h <= clamp_dim(i_cfg_data);
                    default: begin
                    end
                endcase
            end
            case (ctrl.act)
                A_LATCH: begin
                    if (i_start) begin
                        r_cmd <= i_command;
                        r_rv  <= '0;
                    end
                end
                A_CAPTURE: begin
                    r_rv <= bm_rdata;
                end
                A_SEED: begin
                    r_sp <= DepthBits'(1);
                end
                A_PAINT: begin
                    r_sp <= r_sp + DepthBits'(1);
                end
                A_POP: begin
                    r_sp <= sp_m1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (ctrl.act)
            A_LATCH: begin
                r_x     <= i_pos_x;
                r_y     <= i_pos_y;
                r_color <= i_pixel_value;
            end
            A_SEED: begin
                r_cur <= pos_idx;
                r_dir <= 3'd0;
            end
            A_PROBE: begin
                r_pd  <= r_dir[1:0];
                r_dir <= r_dir + 3'd1;
                r_nbr <= probe_nbr;
                r_ok  <= probe_ok;
            end
            A_PAINT: begin
                r_cur <= r_nbr;
                r_dir <= 3'd0;
            end
            A_LOAD: begin
                r_cur <= st_rdata.idx;
                r_dir <= {1'b0, st_rdata.dir} + 3'd1;
            end
            default: begin
            end
        endcase
    end

    assign o_cfg_ready     = 1'b1;
    assign o_result_strobe = r_strobe;
    assign o_read_value    = r_rv;
    assign o_done_command  = r_cmd;

endmodule

// ===== verif/boundary_fill_checker.sv =====
`timescale 1ns / 100ps

module boundary_fill_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [bfe_pkg::CmdBits-1:0]   i_command,
    input  logic [bfe_pkg::CoordBits-1:0] i_pos_x,
    input  logic [bfe_pkg::CoordBits-1:0] i_pos_y,
    input  logic [bfe_pkg::PixelBits-1:0] i_pixel_value,
    input  logic                          i_result_strobe,
    input  logic [bfe_pkg::PixelBits-1:0] i_read_value,
    input  logic [bfe_pkg::CmdBits-1:0]   i_done_command,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [bfe_pkg::DimBits-1:0]   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import bfe_pkg::*;

    localparam int Slots = 8;

    typedef struct packed {
        logic [PixelBits-1:0] read_value;
        logic [CmdBits-1:0]   command;
    } t_done;

    logic [PixelBits-1:0] canvas [Cells];
    logic [IdxBits-1:0]   trail_idx [Cells];
    logic [2:0]           trail_dir [Cells];
    logic [DimBits-1:0]   width_reg;
    logic [DimBits-1:0]   height_reg;
    t_done                awaited [Slots];
    int                   rd_slot = 0;
    int                   wr_slot = 0;
    int                   fail_total = 0;

    function automatic int span(input logic [DimBits-1:0] raw);
        if (raw == '0) begin
            return 1;
        end
        if (raw > GridSize) begin
            return GridSize;
        end
        return int'(raw);
    endfunction

    function automatic void flood(input int sx, input int sy, input logic [PixelBits-1:0] color);
        int       w;
        int       h;
        int       depth;
        int       top;
        int       idx;
        int       x;
        int       y;
        int       n;
        logic [2:0] dir;
        bit       ok;
        w = span(width_reg);
        h = span(height_reg);
        if (sx >= w || sy >= h) begin
            return;
        end
        idx = sy * GridSize + sx;
        if (canvas[idx] == color) begin
            return;
        end
        canvas[idx] = color;
        trail_idx[0] = IdxBits'(idx);
        trail_dir[0] = 3'd0;
        depth = 1;
        while (depth > 0) begin
            top = depth - 1;
            idx = int'(trail_idx[top]);
            dir = trail_dir[top];
            x = idx % GridSize;
            y = idx / GridSize;
            if (dir > 3'd3) begin
                depth = top;
                continue;
            end
            trail_dir[top] = dir + 3'd1;
            case (dir)
                3'd0: begin
                    ok = x > 0;
                    n = idx - 1;
                end
                3'd1: begin
                    ok = x + 1 < w;
                    n = idx + 1;
                end
                3'd2: begin
                    ok = y > 0;
                    n = idx - GridSize;
                end
                default: begin
                    ok = y + 1 < h;
                    n = idx + GridSize;
                end
            endcase
            if (ok && canvas[n] != color) begin
                canvas[n] = color;
                trail_idx[depth] = IdxBits'(n);
                trail_dir[depth] = 3'd0;
                depth++;
            end
        end
    endfunction

    function automatic t_done run_command(input logic [CmdBits-1:0] cmd,
                                          input logic [CoordBits-1:0] x,
                                          input logic [CoordBits-1:0] y,
                                          input logic [PixelBits-1:0] color);
        t_done r;
        int    spot;
        spot = int'(y) * GridSize + int'(x);
        r.read_value = '0;
        r.command = cmd;
        case (cmd)
            CMD_WRITE: canvas[spot] = color;
            CMD_READ:  r.read_value = canvas[spot];
            CMD_FILL:  flood(int'(x), int'(y), color);
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_done want;
        if (!i_rst_n) begin
            for (int i = 0; i < Cells; i++) begin
                canvas[i] = '0;
            end
            width_reg = DimBits'(GridSize);
            height_reg = DimBits'(GridSize);
            rd_slot = 0;
            wr_slot = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_WIDTH) begin
                    width_reg = i_cfg_data;
                end else begin
                    height_reg = i_cfg_data;
                end
            end
            if (i_result_strobe) begin
                if (rd_slot == wr_slot) begin
                    $display("%0t: unexpected result, read_value %h done_command %0d",
                             $time, i_read_value, i_done_command);
                    fail_total++;
                end else begin
                    want = awaited[rd_slot % Slots];
                    rd_slot++;
                    if (i_read_value !== want.read_value) begin
                        $display("%0t: read_value expected %h got %h",
                                 $time, want.read_value, i_read_value);
                        fail_total++;
                    end
                    if (i_done_command !== want.command) begin
                        $display("%0t: done_command expected %0d got %0d",
                                 $time, want.command, i_done_command);
                        fail_total++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                awaited[wr_slot % Slots] = run_command(i_command, i_pos_x, i_pos_y,
                                                       i_pixel_value);
                wr_slot++;
            end
        end
        o_pending <= wr_slot - rd_slot;
        o_fail_count <= fail_total;
    end

endmodule

// ===== verif/boundary_fill_engine_tb.sv =====
`timescale 1ns / 100ps

module boundary_fill_engine_tb;
    import bfe_pkg::*;

    localparam logic [CmdBits-1:0] CMD_ERROR = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic                 o_busy;
    logic [CmdBits-1:0]   i_command = CMD_WRITE;
    logic [CoordBits-1:0] i_pos_x = '0;
    logic [CoordBits-1:0] i_pos_y = '0;
    logic [PixelBits-1:0] i_pixel_value = '0;
    logic                 o_result_strobe;
    logic [PixelBits-1:0] o_read_value;
    logic [CmdBits-1:0]   o_done_command;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_index = REG_WIDTH;
    logic [DimBits-1:0]   i_cfg_data = '0;

    int                   fail_count;
    int                   pending;
    bit                   steady = 1'b0;
    logic [PixelBits-1:0] palette [4];

    always #10 i_clk = ~i_clk;

    boundary_fill_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_command       (i_command),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pixel_value   (i_pixel_value),
        .o_result_strobe (o_result_strobe),
        .o_read_value    (o_read_value),
        .o_done_command  (o_done_command),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    boundary_fill_checker watch (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_command       (i_command),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pixel_value   (i_pixel_value),
        .i_result_strobe (o_result_strobe),
        .i_read_value    (o_read_value),
        .i_done_command  (o_done_command),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    task automatic send(input logic [CmdBits-1:0] cmd, input int x, input int y,
                        input logic [PixelBits-1:0] color);
        int gap;
        if (!steady && $urandom_range(0, 99) < 15) begin
            gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_command <= cmd;
        i_pos_x <= CoordBits'(x);
        i_pos_y <= CoordBits'(y);
        i_pixel_value <= color;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DimBits-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item(input int xmax, input int ymax);
        int                   pick;
        int                   x;
        int                   y;
        logic [CmdBits-1:0]   cmd;
        logic [PixelBits-1:0] color;
        pick = $urandom_range(0, 99);
        cmd = (pick < 40) ? CMD_WRITE : (pick < 70) ? CMD_READ :
              (pick < 95) ? CMD_FILL : CMD_ERROR;
        if ($urandom_range(0, 99) < 85) begin
            x = $urandom_range(0, xmax);
            y = $urandom_range(0, ymax);
        end else begin
            x = $urandom_range(0, GridSize - 1);
            y = $urandom_range(0, GridSize - 1);
        end
        color = ($urandom_range(0, 99) < 80) ? palette[$urandom_range(0, 3)] : $urandom;
        send(cmd, x, y, color);
    endtask

    function automatic logic [DimBits-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return DimBits'($urandom_range(1, 6));
        end
        if (r < 85) begin
            return '0;
        end
        return DimBits'($urandom_range(17, 31));
    endfunction

    function automatic int top_coord(input logic [DimBits-1:0] raw);
        return (raw == '0) ? 0 : (raw > GridSize) ? GridSize - 1 : int'(raw) - 1;
    endfunction

    initial begin
        #200_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [DimBits-1:0] w_raw;
        logic [DimBits-1:0] h_raw;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send(CMD_WRITE, 0, 0, 32'hFFFF_FFFF);
        send(CMD_WRITE, 15, 15, 32'h8000_0001);
        send(CMD_READ, 0, 0, 32'h0);
        send(CMD_READ, 15, 15, 32'hFFFF_FFFF);
        send(CMD_READ, 15, 0, 32'h0);
        send(CMD_ERROR, 15, 15, 32'hFFFF_FFFF);
        send(CMD_FILL, 3, 3, 32'h0);
        send(CMD_FILL, 5, 5, 32'h1234_5678);
        send(CMD_READ, 15, 15, 32'h0);
        send(CMD_READ, 0, 0, 32'h0);
        drain();
        write_reg(REG_WIDTH, 5'd4);
        write_reg(REG_HEIGHT, 5'd3);
        send(CMD_FILL, 8, 8, 32'hA5A5_5A5A);
        send(CMD_FILL, 4, 0, 32'hA5A5_5A5A);
        send(CMD_FILL, 0, 2, 32'hA5A5_5A5A);
        send(CMD_READ, 3, 2, 32'h0);
        send(CMD_READ, 4, 2, 32'h0);
        send(CMD_WRITE, 10, 10, 32'h0BAD_F00D);
        send(CMD_READ, 10, 10, 32'h0);
        drain();
        write_reg(REG_WIDTH, 5'd0);
        write_reg(REG_HEIGHT, 5'd31);
        send(CMD_FILL, 0, 0, 32'h00FF_00FF);
        send(CMD_READ, 0, 15, 32'h0);
        send(CMD_READ, 1, 0, 32'h0);
        drain();
        write_reg(REG_WIDTH, 5'd17);
        write_reg(REG_HEIGHT, 5'd1);
        send(CMD_FILL, 7, 0, 32'h7F7F_7F7F);
        send(CMD_READ, 15, 0, 32'h0);
        send(CMD_READ, 0, 1, 32'h0);

        for (int phase = 0; phase < 12; phase++) begin
            drain();
            if (phase == 0 || phase == 7) begin
                w_raw = DimBits'(GridSize);
                h_raw = DimBits'(GridSize);
            end else begin
                w_raw = pick_dim();
                h_raw = pick_dim();
            end
            write_reg(REG_WIDTH, w_raw);
            write_reg(REG_HEIGHT, h_raw);
            palette[0] = '0;
            palette[1] = $urandom;
            palette[2] = $urandom;
            palette[3] = 32'hFFFF_FFFF;
            steady = (phase == 4);
            repeat (48) random_item(top_coord(w_raw), top_coord(h_raw));
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bfe_pkg.sv
rtl/bfe_bitmap.sv
rtl/bfe_stack.sv
rtl/bfe_useq.sv
rtl/boundary_fill_engine.sv
verif/boundary_fill_checker.sv
verif/boundary_fill_engine_tb.sv
